// ----- rtl/core/spd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed profile derivatives: shared package
// Word types, fixed-point constants, sequencer states and the saturation
// helper used by the sequencer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int DATA_W  = 32;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 84;
  localparam int NUM_W   = 37;
  localparam int U_W     = 48;
  localparam int BLEND_W = 33;
  localparam int CFG_IDX_W = 2;

  // Q16.16 smoothing weights 0.4, 0.3 and 0.7.
  localparam logic signed [MUL_B_W-1:0] K_04 = 33'sd26214;
  localparam logic signed [MUL_B_W-1:0] K_03 = 33'sd19661;
  localparam logic signed [MUL_B_W-1:0] K_07 = 33'sd45875;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_GRID_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_ENABLE  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] smoothed;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] curvature;
    logic                     last_point;
  } out_word_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // Rounding bias preloaded for a later right shift by 16, 17 or 18.
  typedef enum logic [1:0] {
    BIAS_Q16,
    BIAS_Q17,
    BIAS_Q18
  } bias_t;

  typedef struct packed {
    acc_op_t op;
    logic    shift16;
    bias_t   bias;
  } mac_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_A5,
    ST_A6,
    ST_A7,
    ST_A8,
    ST_A9,
    ST_A10,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_EMIT_LONE,
    ST_EMIT_HEAD,
    ST_EMIT_TAIL
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = ACC_W'(32'sh7FFF_FFFF);
    lo_lim = ACC_W'(32'sh8000_0000);
    if (v > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      return 32'sh8000_0000;
    end
    return DATA_W'(v);
  endfunction

endpackage

// ----- rtl/core/spd_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed profile derivatives: shared multiply-accumulate unit
// One signed 34 x 33 multiplier with a registered product, feeding a wide
// accumulator that can load with a rounding bias, add, or hold.
// ----------------------------------------------------------------------------
module spd_mac
  import spd_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  input  mac_ctl_t                  ctl,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  bias;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    addend = ctl.shift16 ? (ACC_W'(prod_r) <<< 16) : ACC_W'(prod_r);
    case (ctl.bias)
      BIAS_Q16: bias = ACC_W'(1) <<< 15;
      BIAS_Q17: bias = ACC_W'(1) <<< 16;
      BIAS_Q18: bias = ACC_W'(1) <<< 17;
      default:  bias = '0;
    endcase
    case (ctl.op)
      ACC_LOAD: acc_nxt = bias + addend;
      ACC_ADD:  acc_nxt = acc_r + addend;
      default:  acc_nxt = acc_r;
    endcase
  end

  assign acc = acc_r;

endmodule

// ----- rtl/core/smoothed_profile_derivatives_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed profile derivatives: top level
// Smooths a run of equally spaced Q16.16 samples and returns, for every
// point, the smoothed value, the first derivative and a curvature term.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_ channel (in_valid / in_stall); the final sample
//   of a run carries last_sample. Results leave on the out_ channel, one word
//   per point, the word for point n-1 marked with last_point. Points lag the
//   input by three samples; the final sample flushes everything still pending.
//   Registers (grid step, its reciprocal, slope enable) are written through
//   cfg_valid / cfg_ready / cfg_index / cfg_data; the user must do so only while
//   the block is idle, as the block itself does not enforce it.
//   The first two samples of a run are only stored; the third also forms the
//   starting slope. Every later sample takes one smoothing pass through the
//   shared multiplier and accumulator, after accept and dispatch. A final
//   sample adds up to one more pass, the closing curvature and the extra
//   result words. in_stall is low only in the idle state.
// Reset and stall:
//   A synchronous reset returns the sequencer to idle, empties the output
//   register and restores the register defaults. A stalled output word holds
//   its value; the sequencer waits at its next emit until the word is taken.
// ----------------------------------------------------------------------------
module smoothed_profile_derivatives_top
  import spd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [DATA_W-1:0] grid_step_r;
  logic [DATA_W-1:0] inv_grid_step_r;
  logic              slope_enable_r;

  // Sequencer control.
  state_t      state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        last_r;
  logic        extra_r, extra_nxt;

  // Working values.
  logic signed [DATA_W-1:0]  x_r;
  logic signed [DATA_W-1:0]  sw0_r, sw0_nxt;
  logic signed [DATA_W-1:0]  sw1_r, sw1_nxt;
  logic signed [DATA_W-1:0]  slope_r, slope_nxt;
  logic signed [DATA_W-1:0]  d1_r, d1_nxt;
  logic signed [DATA_W-1:0]  cv_r, cv_nxt;
  logic signed [BLEND_W-1:0] blend_r, blend_nxt;
  logic signed [U_W-1:0]     u_r, u_nxt;

  // Output register.
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      emit;
  out_word_t emit_word;
  logic      out_free;

  // Shared unit hookup.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  mac_ctl_t                  mac_ctl;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sh16;
  logic signed [ACC_W-1:0]   acc_sh17;
  logic signed [ACC_W-1:0]   acc_sh18;

  // Derived operands.
  logic signed [DATA_W:0]  diff_w;
  logic signed [DATA_W:0]  dd_w;
  logic signed [DATA_W:0]  neg_s_w;
  logic signed [NUM_W-1:0] num_w;
  logic signed [DATA_W-1:0] nx_w;

  logic in_fire;

  spd_mac u_mac (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .ctl   (mac_ctl),
    .acc   (acc)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign acc_sh16 = acc >>> 16;
  assign acc_sh17 = acc >>> 17;
  assign acc_sh18 = acc >>> 18;

  assign diff_w  = (DATA_W + 1)'(sw1_r) - (DATA_W + 1)'(sw0_r);
  assign dd_w    = (DATA_W + 1)'(d1_r) - (DATA_W + 1)'(slope_r);
  assign neg_s_w = (DATA_W + 1)'(0) - (DATA_W + 1)'(slope_r);
  // Starting slope numerator 10 x1 - 7 x0 - 3 x2 built from shifts and adds.
  assign num_w = (NUM_W'(sw1_r) <<< 3) + (NUM_W'(sw1_r) <<< 1)
               - (NUM_W'(sw0_r) <<< 3) + NUM_W'(sw0_r)
               - (NUM_W'(x_r) <<< 1) - NUM_W'(x_r);
  assign nx_w = sat32(acc_sh16 + ACC_W'(blend_r));

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_step_r     <= 32'd65536;
      inv_grid_step_r <= 32'd65536;
      slope_enable_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_STEP:     grid_step_r     <= cfg_data;
        CFG_INV_GRID_STEP: inv_grid_step_r <= cfg_data;
        CFG_SLOPE_ENABLE:  slope_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      extra_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      extra_r <= extra_nxt;
      if (in_fire) begin
        last_r <= in_word.last_sample;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_word.sample;
    end
    if (emit) begin
      out_word_r <= emit_word;
    end
    sw0_r   <= sw0_nxt;
    sw1_r   <= sw1_nxt;
    slope_r <= slope_nxt;
    d1_r    <= d1_nxt;
    cv_r    <= cv_nxt;
    blend_r <= blend_nxt;
    u_r     <= u_nxt;
  end

  // Sequencer: at most one multiply issued per state; the accumulator works on
  // the product of the previous state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    extra_nxt = extra_r;
    sw0_nxt   = sw0_r;
    sw1_nxt   = sw1_r;
    slope_nxt = slope_r;
    d1_nxt    = d1_r;
    cv_nxt    = cv_r;
    blend_nxt = blend_r;
    u_nxt     = u_r;
    mul_a     = '0;
    mul_b     = '0;
    mac_ctl   = '{op: ACC_HOLD, shift16: 1'b0, bias: BIAS_Q16};
    emit      = 1'b0;
    emit_word = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (cnt_r)
          2'd0: begin
            sw0_nxt   = x_r;
            slope_nxt = '0;
            if (last_r) begin
              state_nxt = ST_EMIT_LONE;
            end else begin
              cnt_nxt   = 2'd1;
              state_nxt = ST_IDLE;
            end
          end
          2'd1: begin
            sw1_nxt = x_r;
            if (last_r) begin
              state_nxt = ST_EMIT_HEAD;
            end else begin
              cnt_nxt   = 2'd2;
              state_nxt = ST_IDLE;
            end
          end
          2'd2: begin
            u_nxt     = U_W'(num_w);
            state_nxt = ST_S1;
          end
          default: begin
            extra_nxt = last_r;
            state_nxt = ST_A1;
          end
        endcase
      end

      // Starting slope: numerator times 1/h, split into low and high halves.
      ST_S1: begin
        mul_a     = MUL_A_W'(u_r[15:0]);
        mul_b     = MUL_B_W'(inv_grid_step_r);
        state_nxt = ST_S2;
      end
      ST_S2: begin
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q18};
        mul_a     = MUL_A_W'($signed(u_r[U_W-1:16]));
        mul_b     = MUL_B_W'(inv_grid_step_r);
        state_nxt = ST_S3;
      end
      ST_S3: begin
        mac_ctl   = '{op: ACC_ADD, shift16: 1'b1, bias: BIAS_Q16};
        state_nxt = ST_S4;
      end
      ST_S4: begin
        slope_nxt = slope_enable_r ? sat32(acc_sh18) : '0;
        if (last_r) begin
          state_nxt = ST_A1;
        end else begin
          cnt_nxt   = 2'd3;
          state_nxt = ST_IDLE;
        end
      end

      // One smoothing step: new slope, blended sample, curvature.
      ST_A1: begin
        mul_a     = {diff_w, 1'b0};
        mul_b     = MUL_B_W'(inv_grid_step_r);
        state_nxt = ST_A2;
      end
      ST_A2: begin
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q16};
        mul_a     = MUL_A_W'(sw1_r);
        mul_b     = K_07;
        state_nxt = ST_A3;
      end
      ST_A3: begin
        d1_nxt    = sat32(acc_sh16 - ACC_W'(slope_r));
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q16};
        mul_a     = MUL_A_W'(x_r);
        mul_b     = K_03;
        state_nxt = ST_A4;
      end
      ST_A4: begin
        mac_ctl   = '{op: ACC_ADD, shift16: 1'b0, bias: BIAS_Q16};
        mul_a     = MUL_A_W'(d1_r);
        mul_b     = MUL_B_W'(grid_step_r);
        state_nxt = ST_A5;
      end
      ST_A5: begin
        blend_nxt = BLEND_W'(acc_sh16);
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q16};
        mul_a     = MUL_A_W'(dd_w);
        mul_b     = MUL_B_W'(inv_grid_step_r);
        state_nxt = ST_A6;
      end
      ST_A6: begin
        u_nxt     = U_W'(acc_sh16);
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q17};
        state_nxt = ST_A7;
      end
      ST_A7: begin
        cv_nxt    = sat32(acc_sh17);
        mul_a     = MUL_A_W'(u_r[15:0]);
        mul_b     = K_04;
        state_nxt = ST_A8;
      end
      ST_A8: begin
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q16};
        mul_a     = MUL_A_W'($signed(u_r[U_W-1:16]));
        mul_b     = K_04;
        state_nxt = ST_A9;
      end
      ST_A9: begin
        mac_ctl   = '{op: ACC_ADD, shift16: 1'b1, bias: BIAS_Q16};
        state_nxt = ST_A10;
      end
      ST_A10: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = '{smoothed: sw0_r, slope: slope_r, curvature: cv_r,
                        last_point: 1'b0};
          sw0_nxt   = sw1_r;
          sw1_nxt   = nx_w;
          slope_nxt = d1_r;
          if (extra_r) begin
            extra_nxt = 1'b0;
            state_nxt = ST_A1;
          end else if (last_r) begin
            state_nxt = ST_F1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      // End of run: curvature of the next to last point against a zero slope.
      ST_F1: begin
        mul_a     = MUL_A_W'(neg_s_w);
        mul_b     = MUL_B_W'(inv_grid_step_r);
        state_nxt = ST_F2;
      end
      ST_F2: begin
        mac_ctl   = '{op: ACC_LOAD, shift16: 1'b0, bias: BIAS_Q17};
        state_nxt = ST_F3;
      end
      ST_F3: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = '{smoothed: sw0_r, slope: slope_r, curvature: sat32(acc_sh17),
                        last_point: 1'b0};
          state_nxt = ST_EMIT_TAIL;
        end
      end

      ST_EMIT_LONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = '{smoothed: sw0_r, slope: '0, curvature: '0, last_point: 1'b1};
          cnt_nxt   = 2'd0;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_HEAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = '{smoothed: sw0_r, slope: '0, curvature: '0, last_point: 1'b0};
          state_nxt = ST_EMIT_TAIL;
        end
      end
      ST_EMIT_TAIL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = '{smoothed: sw1_r, slope: '0, curvature: '0, last_point: 1'b1};
          cnt_nxt   = 2'd0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A run of one sample is emitted only from an empty count.
  a_lone_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LONE) |-> (cnt_r == 2'd0))
    else $error("single-sample run emitted with nonzero count");

  // A second smoothing pass is only scheduled for the final sample.
  a_extra_last: assert property (@(posedge clk) disable iff (!rst_n)
    extra_r |-> last_r)
    else $error("extra smoothing pass outside end of run");

  // The last point of a run always carries zero slope and curvature.
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_point) |->
      (out_word.slope == '0 && out_word.curvature == '0))
    else $error("last point with nonzero derivative");

  // With the slope disabled the starting slope is cleared.
  a_slope_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S4 && !slope_enable_r) |=> (slope_r == '0))
    else $error("starting slope not zero while disabled");

  // An accepted sample is always dispatched on the following cycle.
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DISPATCH))
    else $error("accepted sample not dispatched");

endmodule
